>>> src/csm_pkg.sv
`timescale 1ns / 1ps
package csm_pkg;

    localparam int unsigned ACC_W      = 48;
    localparam int unsigned ELEM_W     = 16;
    localparam int unsigned PROD_W     = 2 * ACC_W;
    localparam int unsigned HALF_W     = ACC_W / 2;
    localparam int unsigned SQRT_STEPS = ACC_W;
    localparam int unsigned DVD_W      = ACC_W + 15;
    localparam int unsigned DIV_STEPS  = DVD_W;
    localparam int unsigned MUL_STEPS  = 4;
    localparam int unsigned CNT_W      = 6;

    localparam logic signed [ELEM_W-1:0] THRESH_RESET = 16'sd22938;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } csm_state_t;

    typedef struct packed {
        logic       acc_en;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       sqrt_init;
        logic       sqrt_en;
        logic       div_init;
        logic       div_en;
        logic       load_out;
    } csm_cmd_t;

    typedef struct packed {
        logic out_free;
    } csm_status_t;

endpackage

>>> src/csm_in_if.sv
`timescale 1ns / 1ps
interface csm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] lhs_element;
    logic signed [15:0] rhs_element;
    logic               last_element;

    modport source (output valid, lhs_element, rhs_element, last_element, input ready);
    modport sink   (input valid, lhs_element, rhs_element, last_element, output ready);
endinterface

>>> src/csm_out_if.sv
`timescale 1ns / 1ps
interface csm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] similarity;
    logic               is_match;
    logic               zero_norm;

    modport source (output valid, similarity, is_match, zero_norm, input ready);
    modport sink   (input valid, similarity, is_match, zero_norm, output ready);
endinterface

>>> src/csm_cfg_if.sv
`timescale 1ns / 1ps
interface csm_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] match_threshold;

    modport source (output valid, match_threshold, input ready);
    modport sink   (input valid, match_threshold, output ready);
endinterface

>>> src/csm_ctrl.sv
`timescale 1ns / 1ps
module csm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  csm_pkg::csm_status_t status,
    output csm_pkg::csm_cmd_t    cmd
);
    import csm_pkg::*;

    csm_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cmd.mul_idx = cnt_reg[1:0];
        case (state_reg)
            ST_ACCUM:
            begin
                in_ready   = 1'b1;
                cmd.acc_en = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_MUL;
                    cnt_next   = '0;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = ST_SQRT;
                    cnt_next      = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SQRT:
            begin
                cmd.sqrt_en = 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                    cnt_next     = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
                state_next = ST_ACCUM;
        endcase
    end
endmodule

>>> src/csm_dp.sv
`timescale 1ns / 1ps
module csm_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csm_pkg::csm_cmd_t    cmd,
    output csm_pkg::csm_status_t status,
    input  logic signed [15:0]   lhs_element,
    input  logic signed [15:0]   rhs_element,
    input  logic                 cfg_valid,
    input  logic signed [15:0]   cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic signed [15:0]   similarity,
    output logic                 is_match,
    output logic                 zero_norm
);
    import csm_pkg::*;

    logic signed [ACC_W-1:0] dot_reg;
    logic [ACC_W-1:0]        lhs_en_reg, rhs_en_reg;
    logic signed [15:0]      thresh_reg;
    logic [PROD_W-1:0]       rad_reg;
    logic [ACC_W+1:0]        srem_reg;
    logic [ACC_W-1:0]        root_reg;
    logic [DVD_W-1:0]        dvd_reg;
    logic [DVD_W-1:0]        quo_reg;
    logic [ACC_W-1:0]        drem_reg;
    logic                    neg_reg;
    logic                    out_valid_reg;
    logic signed [15:0]      sim_reg;
    logic                    match_reg, zero_reg;

    // accumulate with saturation
    logic signed [31:0]    pd, pl, pr;
    logic signed [ACC_W:0] dot_sum;
    logic [ACC_W:0]        lhs_sum, rhs_sum;
    logic signed [ACC_W-1:0] dot_next;
    logic [ACC_W-1:0]      lhs_next, rhs_next;

    assign pd = lhs_element * rhs_element;
    assign pl = lhs_element * lhs_element;
    assign pr = rhs_element * rhs_element;
    assign dot_sum = {dot_reg[ACC_W-1], dot_reg} + (ACC_W+1)'(pd);
    assign lhs_sum = {1'b0, lhs_en_reg} + (ACC_W+1)'(unsigned'(pl));
    assign rhs_sum = {1'b0, rhs_en_reg} + (ACC_W+1)'(unsigned'(pr));

    always_comb
    begin
        if (dot_sum[ACC_W] != dot_sum[ACC_W-1])
            dot_next = dot_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            dot_next = dot_sum[ACC_W-1:0];
        lhs_next = lhs_sum[ACC_W] ? {ACC_W{1'b1}} : lhs_sum[ACC_W-1:0];
        rhs_next = rhs_sum[ACC_W] ? {ACC_W{1'b1}} : rhs_sum[ACC_W-1:0];
    end

    // energy product, one 24x24 partial product a step
    logic [HALF_W-1:0]   ma, mb;
    logic [2*HALF_W-1:0] mterm;
    logic [PROD_W-1:0]   mshift;

    always_comb
    begin
        ma     = cmd.mul_idx[1] ? lhs_en_reg[ACC_W-1:HALF_W] : lhs_en_reg[HALF_W-1:0];
        mb     = cmd.mul_idx[0] ? rhs_en_reg[ACC_W-1:HALF_W] : rhs_en_reg[HALF_W-1:0];
        mterm  = ma * mb;
        mshift = PROD_W'(mterm) << (HALF_W * (32'(cmd.mul_idx[1]) + 32'(cmd.mul_idx[0])));
    end

    // square root step, two radicand bits a step
    logic [ACC_W+3:0] srem_sh, strial, sdiff;
    assign srem_sh = {srem_reg, rad_reg[PROD_W-1:PROD_W-2]};
    assign strial  = {2'b00, root_reg, 2'b01};
    assign sdiff   = srem_sh - strial;

    // restoring divide step
    logic [ACC_W:0] drem_sh, ddiff;
    logic           dge;
    assign drem_sh = {drem_reg, dvd_reg[DVD_W-1]};
    assign ddiff   = drem_sh - {1'b0, root_reg};
    assign dge     = drem_sh >= {1'b0, root_reg};

    logic [ACC_W-1:0] mag;
    assign mag = dot_reg[ACC_W-1] ? ACC_W'(-dot_reg) : ACC_W'(dot_reg);

    // final saturation and compare
    logic signed [15:0] sim_calc;
    logic               zero_calc;
    always_comb
    begin
        zero_calc = (lhs_en_reg == '0) || (rhs_en_reg == '0);
        if (neg_reg)
            sim_calc = (quo_reg > DVD_W'(32768)) ? -16'sd32768 : 16'(-quo_reg[15:0]);
        else
            sim_calc = (quo_reg > DVD_W'(32767)) ? 16'sd32767 : signed'(quo_reg[15:0]);
        if (zero_calc)
            sim_calc = '0;
    end

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg       <= '0;
            lhs_en_reg    <= '0;
            rhs_en_reg    <= '0;
            thresh_reg    <= THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                thresh_reg <= cfg_data;
            if (cmd.acc_en)
            begin
                dot_reg    <= dot_next;
                lhs_en_reg <= lhs_next;
                rhs_en_reg <= rhs_next;
            end
            else if (cmd.load_out)
            begin
                dot_reg    <= '0;
                lhs_en_reg <= '0;
                rhs_en_reg <= '0;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            rad_reg <= (cmd.mul_idx == 2'd0) ? mshift : rad_reg + mshift;
        else if (cmd.sqrt_en)
            rad_reg <= rad_reg << 2;

        if (cmd.sqrt_init)
        begin
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_en)
        begin
            if (srem_sh >= strial)
            begin
                srem_reg <= sdiff[ACC_W+1:0];
                root_reg <= {root_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh[ACC_W+1:0];
                root_reg <= {root_reg[ACC_W-2:0], 1'b0};
            end
        end

        if (cmd.div_init)
        begin
            dvd_reg  <= {mag, 15'd0};
            quo_reg  <= '0;
            drem_reg <= '0;
            neg_reg  <= dot_reg[ACC_W-1];
        end
        else if (cmd.div_en)
        begin
            dvd_reg  <= dvd_reg << 1;
            quo_reg  <= {quo_reg[DVD_W-2:0], dge};
            drem_reg <= dge ? ddiff[ACC_W-1:0] : drem_sh[ACC_W-1:0];
        end

        if (cmd.load_out)
        begin
            sim_reg   <= sim_calc;
            zero_reg  <= zero_calc;
            match_reg <= !zero_calc && (sim_calc > thresh_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign similarity = sim_reg;
    assign is_match   = match_reg;
    assign zero_norm  = zero_reg;
endmodule

>>> src/cosine_similarity_match.sv
`timescale 1ns / 1ps
// Streaming cosine similarity with threshold. Element pairs (signed Q1.15) are
// taken one per cycle while input ready is high and folded into a saturating
// dot product and two squared norms. The request carrying last_element ends
// the vector: input ready then drops through 4 partial products of the 48x48
// norm product, 48 steps of the bit-serial square root, 63 steps of the
// bit-serial divider and the wait to load the result register. The result,
// similarity in Q1.15 saturated, is_match (strictly above match_threshold) and
// zero_norm, sits in an output register until taken; accumulators are cleared
// when it is loaded. match_threshold resets to 22938 (0.7) and may be written
// whenever the block is idle.
module cosine_similarity_match (
    input  logic      clk,
    input  logic      rst_n,
    csm_in_if.sink    in_ch,
    csm_out_if.source out_ch,
    csm_cfg_if.sink   cfg_ch
);
    import csm_pkg::*;

    csm_cmd_t    cmd;
    csm_status_t status;

    // threshold register always takes writes
    assign cfg_ch.ready = 1'b1;

    csm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.last_element),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    csm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .lhs_element (in_ch.lhs_element),
        .rhs_element (in_ch.rhs_element),
        .cfg_valid   (cfg_ch.valid),
        .cfg_data    (cfg_ch.match_threshold),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .similarity  (out_ch.similarity),
        .is_match    (out_ch.is_match),
        .zero_norm   (out_ch.zero_norm)
    );
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import csm_pkg::*;

    typedef struct {
        logic signed [15:0] lhs;
        logic signed [15:0] rhs;
        logic               last;
    } pair_t;

    typedef struct {
        logic signed [15:0] similarity;
        logic               is_match;
        logic               zero_norm;
    } score_t;

    localparam logic signed [47:0] DOT_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] DOT_LO = 48'sh8000_0000_0000;
    localparam logic [47:0] NRG_HI = 48'hFFFF_FFFF_FFFF;
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    csm_in_if  in_ch();
    csm_out_if out_ch();
    csm_cfg_if cfg_ch();

    cosine_similarity_match dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state: its own copy of the accumulators and the threshold
    logic signed [47:0] dot_sum;
    logic [47:0]        lhs_nrg;
    logic [47:0]        rhs_nrg;
    logic signed [15:0] thresh;

    pair_t  pending_pairs[$];
    score_t expected_scores[$];
    int     failures = 0;
    bit     hold_sender = 1'b0;

    // floor(sqrt(a*b)) by restoring bit search over the 96-bit product
    function automatic logic [47:0] root_of_product(logic [47:0] a, logic [47:0] b);
        logic [95:0] prod;
        logic [47:0] r;
        logic [47:0] c;
        prod = a * b;
        r = '0;
        for (int i = 47; i >= 0; i--)
        begin
            c = r | (48'd1 << i);
            if ({48'd0, c} * {48'd0, c} <= prod)
                r = c;
        end
        return r;
    endfunction

    // Fold one request into the accumulators; returns 1 with a score on last
    function automatic bit fold_pair(pair_t p, output score_t s);
        logic signed [49:0] d;
        logic [48:0]        e;
        logic [47:0]        den;
        logic [47:0]        mag;
        logic [63:0]        q;
        d = 50'(dot_sum) + 50'(32'(p.lhs) * 32'(p.rhs));
        if (d > 50'(DOT_HI))
            dot_sum = DOT_HI;
        else if (d < 50'(DOT_LO))
            dot_sum = DOT_LO;
        else
            dot_sum = d[47:0];
        e = {1'b0, lhs_nrg} + 49'(32'(p.lhs) * 32'(p.lhs));
        lhs_nrg = e[48] ? NRG_HI : e[47:0];
        e = {1'b0, rhs_nrg} + 49'(32'(p.rhs) * 32'(p.rhs));
        rhs_nrg = e[48] ? NRG_HI : e[47:0];
        s.similarity = '0;
        s.is_match = 1'b0;
        s.zero_norm = 1'b0;
        if (!p.last)
            return 0;
        if (lhs_nrg == 0 || rhs_nrg == 0)
            s.zero_norm = 1'b1;
        else
        begin
            den = root_of_product(lhs_nrg, rhs_nrg);
            mag = dot_sum[47] ? -dot_sum : dot_sum;
            q = ({16'd0, mag} << 15) / {16'd0, den};
            if (dot_sum[47])
                s.similarity = (q > 64'd32768) ? 16'sh8000 : 16'(-q);
            else
                s.similarity = (q > 64'd32767) ? 16'sh7FFF : 16'(q);
            s.is_match = s.similarity > thresh;
        end
        dot_sum = '0;
        lhs_nrg = '0;
        rhs_nrg = '0;
        return 1;
    endfunction

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // Random vector of dims pairs; some modes correlate rhs with lhs
    task automatic queue_vector(int dims);
        pair_t p;
        int mode;
        mode = $urandom_range(0, 5);
        for (int i = 0; i < dims; i++)
        begin
            p.lhs = rand_elem();
            case (mode)
                0: p.rhs = p.lhs;
                1: p.rhs = -p.lhs;
                2: p.rhs = p.lhs + 16'(int'($urandom_range(0, 200)) - 100);
                3: p.rhs = '0;
                default: p.rhs = rand_elem();
            endcase
            p.last = (i == dims - 1);
            pending_pairs.insert(pending_pairs.size(), p);
        end
    endtask

    task automatic queue_pair(logic signed [15:0] l, logic signed [15:0] r, logic last);
        pair_t p;
        p.lhs = l;
        p.rhs = r;
        p.last = last;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    // Wait until every queued request has gone and every score has come back
    task automatic drain();
        while (pending_pairs.size() != 0 || expected_scores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(logic signed [15:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.match_threshold <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        thresh = v;
        cfg_ch.valid <= 1'b0;
    endtask

    // Sender: bursts and gaps; stays quiet while hold_sender is set
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        score_t s;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.lhs_element <= '0;
            in_ch.rhs_element <= '0;
            in_ch.last_element <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                if (fold_pair('{in_ch.lhs_element, in_ch.rhs_element, in_ch.last_element}, s))
                    expected_scores.insert(expected_scores.size(), s);
                void'(pending_pairs.pop_front());
            end
            if (gap_left > 0)
                gap_left--;
            else if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                    gap_left = $urandom_range(0, 6);
            end
            if (in_ch.valid && !in_ch.ready)
            begin
                // request still waiting: hold it as it is
            end
            else if (pending_pairs.size() == 0 || hold_sender || gap_left > 0)
                in_ch.valid <= 1'b0;
            else
            begin
                in_ch.valid <= 1'b1;
                in_ch.lhs_element <= pending_pairs[0].lhs;
                in_ch.rhs_element <= pending_pairs[0].rhs;
                in_ch.last_element <= pending_pairs[0].last;
                if (burst_left > 0)
                    burst_left--;
            end
        end
    end

    // Receiver: stall pattern shifts through phases of its own
    int stall_phase = 0;

    always @(posedge clk or negedge rst_n)
    begin
        score_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $error("similarity result with no expectation waiting");
                    failures++;
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (out_ch.similarity !== want.similarity)
                    begin
                        $error("similarity: expected %0d, got %0d",
                               want.similarity, out_ch.similarity);
                        failures++;
                    end
                    if (out_ch.is_match !== want.is_match)
                    begin
                        $error("is_match: expected %0b, got %0b",
                               want.is_match, out_ch.is_match);
                        failures++;
                    end
                    if (out_ch.zero_norm !== want.zero_norm)
                    begin
                        $error("zero_norm: expected %0b, got %0b",
                               want.zero_norm, out_ch.zero_norm);
                        failures++;
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 1000;
            if (stall_phase < 300)
                out_ch.ready <= 1'b1;
            else if (stall_phase < 700)
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            else
                out_ch.ready <= ($urandom_range(0, 9) == 0) ? 1'b1 : (stall_phase[3:0] < 4);
        end
    end

    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int sent;
        cfg_ch.valid = 1'b0;
        cfg_ch.match_threshold = '0;
        dot_sum = '0;
        lhs_nrg = '0;
        rhs_nrg = '0;
        thresh = THRESH_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, zero norm, exact +/-1.0, single element vectors
        queue_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        queue_pair(16'sh8000, 16'sh8000, 1'b1);
        queue_pair(16'sh8000, 16'sh7FFF, 1'b1);
        queue_pair(16'sh7FFF, 16'sh8000, 1'b1);
        queue_pair(16'sd0, 16'sd0, 1'b1);
        queue_pair(16'sd5, 16'sd0, 1'b1);
        queue_pair(16'sd0, -16'sd7, 1'b1);
        queue_pair(16'sd3, 16'sd4, 1'b0);
        queue_pair(16'sd4, -16'sd3, 1'b1);
        queue_pair(16'sd100, 16'sd70, 1'b0);
        queue_pair(-16'sd5, 16'sd71, 1'b1);
        queue_pair(16'sd1, 16'sd1, 1'b0);
        queue_pair(16'sd0, 16'sd0, 1'b1);
        queue_pair(-16'sd1, 16'sd1, 1'b1);
        queue_pair(16'sh5555, 16'shAAAA, 1'b0);
        queue_pair(16'shAAAA, 16'sh5555, 1'b1);
        drain();

        // Several thresholds, extremes among them; pause between phases
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_threshold(16'sh7FFF);
                1: set_threshold(16'sh8000);
                2: set_threshold(16'sd0);
                3: set_threshold(16'sd32767 - 16'sd1);
                4: set_threshold(16'($urandom));
                default: set_threshold(THRESH_RESET);
            endcase
            sent = 0;
            while (sent < 225)
            begin
                int dims;
                dims = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 512)
                                                     : $urandom_range(1, 12);
                queue_vector(dims);
                sent += dims;
            end
            if (ph == 2)
            begin
                // hold off until every score so far is back
                while (expected_scores.size() != 0 || pending_pairs.size() != 0)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (expected_scores.size() != 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
src/csm_pkg.sv
src/csm_in_if.sv
src/csm_out_if.sv
src/csm_cfg_if.sv
src/csm_ctrl.sv
src/csm_dp.sv
src/cosine_similarity_match.sv
dv/testbench.sv
